// ----- hw/rtl/i2d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_pkg: shared types and constants for the integer to decimal converter
// Character codes, the double-dabble step size and the sequencer states.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // Width of one packed BCD digit.
  localparam int unsigned DIGIT_BITS = 4;
  // Magnitude bits shifted into the BCD register per cycle.
  localparam int unsigned DABBLE_STEP = 4;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_DONE
  } conv_state_e;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_SIGN,
    EMIT_SKIP,
    EMIT_DIGIT
  } emit_state_e;

endpackage

// ----- hw/rtl/int32_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii: signed integer to decimal ASCII text
// Flow: a queued value goes through the 8-pass double-dabble converter at
//   WORD_BITS = 32, then the emitter sends any sign, skips leading zeros
//   and sends the remaining digits; the converter takes the next value
//   while the emitter still sends the characters of the last one.
// Reset: asynchronous, active low; clears queue, converter and output state.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input transaction: push while not full.
  input  logic                 push,
  output logic                 full,
  input  logic [WORD_BITS-1:0] value_i,
  // Result transaction: pop while not empty.
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           character_o,
  output logic                 last_char_o
);

  // Decimal digits of the largest magnitude, 2^(WORD_BITS-1).
  // 30103/100000 approximates log10(2) closely enough for 8..64 bits.
  localparam int unsigned NUM_DIGITS = ((WORD_BITS - 1) * 30103) / 100000 + 1;
  localparam int unsigned DB         = i2d_pkg::DIGIT_BITS;
  localparam int unsigned ENTRY_W    = WORD_BITS + 1;

  logic                      wr_en, front_neg;
  logic [WORD_BITS-1:0]      front_mag;
  logic [ENTRY_W-1:0]        q_rd_data;
  logic                      q_empty, q_pop;
  logic                      bcd_valid, bcd_ready, bcd_neg;
  logic [NUM_DIGITS*DB-1:0]  bcd_digits;

  // Front: classify sign and form the unsigned magnitude.
  i2d_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .push_i      (push),
    .value_i     (value_i),
    .queue_full_i(full),
    .wr_en_o     (wr_en),
    .neg_o       (front_neg),
    .mag_o       (front_mag)
  );

  // Short queue so the input side keeps taking transactions while the
  // converter works.
  i2d_fifo #(
    .WIDTH(ENTRY_W)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_data_i({front_neg, front_mag}),
    .rd_en_i  (q_pop),
    .rd_data_o(q_rd_data),
    .full_o   (full),
    .empty_o  (q_empty)
  );

  // Back, part one: iterative binary to BCD.
  i2d_bcd #(
    .WORD_BITS (WORD_BITS),
    .NUM_DIGITS(NUM_DIGITS)
  ) u_bcd (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_empty_i(q_empty),
    .neg_i        (q_rd_data[ENTRY_W-1]),
    .mag_i        (q_rd_data[WORD_BITS-1:0]),
    .queue_pop_o  (q_pop),
    .valid_o      (bcd_valid),
    .ready_i      (bcd_ready),
    .neg_o        (bcd_neg),
    .bcd_o        (bcd_digits)
  );

  // Back, part two: emit sign and significant digits, one per cycle while the
  // pop side keeps it free, into the output register that the pop side drains.
  i2d_emit #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (bcd_valid),
    .ready_o    (bcd_ready),
    .neg_i      (bcd_neg),
    .bcd_i      (bcd_digits),
    .pop_i      (pop),
    .empty_o    (empty),
    .character_o(character_o),
    .last_char_o(last_char_o)
  );

endmodule

// ----- hw/rtl/i2d_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_front: input stage
// Accepts an integer, splits it into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module i2d_front #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 push_i,
  input  logic [WORD_BITS-1:0] value_i,
  input  logic                 queue_full_i,
  output logic                 wr_en_o,
  output logic                 neg_o,
  output logic [WORD_BITS-1:0] mag_o
);

  assign wr_en_o = push_i && !queue_full_i;
  assign neg_o   = value_i[WORD_BITS-1];
  // Two's complement negate; the most negative value maps onto itself,
  // which read as unsigned is exactly its magnitude.
  assign mag_o   = neg_o ? (~value_i + {{(WORD_BITS-1){1'b0}}, 1'b1}) : value_i;

endmodule

// ----- hw/rtl/i2d_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_fifo: two-entry queue
// Decouples the input stage from the converter.
// ----------------------------------------------------------------------------
module i2d_fifo #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 2'd1;
    end else if (!do_wr && do_rd) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hw/rtl/i2d_bcd.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_bcd: binary to BCD converter
// Iterative double dabble, several magnitude bits per cycle.
// ----------------------------------------------------------------------------
module i2d_bcd #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     queue_empty_i,
  input  logic                                     neg_i,
  input  logic [WORD_BITS-1:0]                     mag_i,
  output logic                                     queue_pop_o,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic                                     neg_o,
  output logic [NUM_DIGITS*i2d_pkg::DIGIT_BITS-1:0] bcd_o
);

  localparam int unsigned STEP   = i2d_pkg::DABBLE_STEP;
  localparam int unsigned DB     = i2d_pkg::DIGIT_BITS;
  localparam int unsigned BCD_W  = NUM_DIGITS * DB;
  localparam int unsigned MAG_W  = ((WORD_BITS + STEP - 1) / STEP) * STEP;
  localparam int unsigned PASSES = MAG_W / STEP;
  localparam int unsigned PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(PASSES - 1);

  i2d_pkg::conv_state_e state_q, state_d;
  logic [PASS_W-1:0]    pass_q, pass_d;
  logic [MAG_W-1:0]     mag_q, mag_nx;
  logic [BCD_W-1:0]     bcd_q, bcd_nx;
  logic                 neg_q;
  logic                 load, run;

  // One pass of double dabble: per bit, add 3 to every digit at 5 or
  // above, then shift the next magnitude bit in.
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [MAG_W-1:0] m;
    b = bcd_q;
    m = mag_q;
    for (int s = 0; s < STEP; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (b[d*DB +: DB] >= 4'd5) begin
          b[d*DB +: DB] = b[d*DB +: DB] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
    end
    bcd_nx = b;
    mag_nx = m;
  end

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    queue_pop_o = 1'b0;
    run         = 1'b0;
    case (state_q)
      i2d_pkg::CONV_IDLE: begin
        if (!queue_empty_i) begin
          queue_pop_o = 1'b1;
          state_d     = i2d_pkg::CONV_RUN;
        end
      end
      i2d_pkg::CONV_RUN: begin
        run    = 1'b1;
        pass_d = pass_q + PASS_W'(1);
        if (pass_q == LAST_PASS) begin
          state_d = i2d_pkg::CONV_DONE;
        end
      end
      i2d_pkg::CONV_DONE: begin
        // Hand off and, if one is queued, start on the next magnitude in the same cycle.
        if (ready_i) begin
          if (!queue_empty_i) begin
            queue_pop_o = 1'b1;
            state_d     = i2d_pkg::CONV_RUN;
          end else begin
            state_d = i2d_pkg::CONV_IDLE;
          end
        end
      end
      default: begin
        state_d = i2d_pkg::CONV_IDLE;
      end
    endcase
    load = queue_pop_o;
    if (load) begin
      pass_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2d_pkg::CONV_IDLE;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mag_q <= MAG_W'(mag_i);
      bcd_q <= '0;
      neg_q <= neg_i;
    end else if (run) begin
      mag_q <= mag_nx;
      bcd_q <= bcd_nx;
    end
  end

  assign valid_o = (state_q == i2d_pkg::CONV_DONE);
  assign neg_o   = neg_q;
  assign bcd_o   = bcd_q;

endmodule

// ----- hw/rtl/i2d_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_emit: character sequencer
// Drops leading zeros and sends sign and digits through an output register.
// ----------------------------------------------------------------------------
module i2d_emit #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  logic                                      neg_i,
  input  logic [NUM_DIGITS*i2d_pkg::DIGIT_BITS-1:0] bcd_i,
  input  logic                                      pop_i,
  output logic                                      empty_o,
  output logic [7:0]                                character_o,
  output logic                                      last_char_o
);

  localparam int unsigned DB    = i2d_pkg::DIGIT_BITS;
  localparam int unsigned BCD_W = NUM_DIGITS * DB;
  localparam int unsigned CNT_W = $clog2(NUM_DIGITS + 1);

  i2d_pkg::emit_state_e state_q, state_d;
  logic [BCD_W-1:0]     dig_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 out_valid_q;
  logic [7:0]           out_char_q;
  logic                 out_last_q;

  logic                 slot_free, load, shift, emit, emit_last;
  logic [7:0]           emit_char;
  logic [DB-1:0]        top_digit;

  assign slot_free = !out_valid_q || pop_i;
  assign top_digit = dig_q[BCD_W-1 -: DB];

  always_comb begin
    state_d   = state_q;
    ready_o   = 1'b0;
    load      = 1'b0;
    shift     = 1'b0;
    emit      = 1'b0;
    emit_char = i2d_pkg::CHAR_ZERO;
    emit_last = 1'b0;
    case (state_q)
      i2d_pkg::EMIT_IDLE: begin
        if (valid_i) begin
          ready_o = 1'b1;
          load    = 1'b1;
          state_d = neg_i ? i2d_pkg::EMIT_SIGN : i2d_pkg::EMIT_SKIP;
        end
      end
      i2d_pkg::EMIT_SIGN: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = i2d_pkg::CHAR_MINUS;
          state_d   = i2d_pkg::EMIT_SKIP;
        end
      end
      i2d_pkg::EMIT_SKIP: begin
        // Drop leading zeros, but always keep the final digit.
        if ((top_digit == '0) && (cnt_q > CNT_W'(1))) begin
          shift = 1'b1;
        end else begin
          state_d = i2d_pkg::EMIT_DIGIT;
        end
      end
      i2d_pkg::EMIT_DIGIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = i2d_pkg::CHAR_ZERO + {4'd0, top_digit};
          emit_last = (cnt_q == CNT_W'(1));
          shift     = 1'b1;
          if (emit_last) begin
            state_d = i2d_pkg::EMIT_IDLE;
          end
        end
      end
      default: begin
        state_d = i2d_pkg::EMIT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2d_pkg::EMIT_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cnt_q <= CNT_W'(NUM_DIGITS);
      end else if (shift) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dig_q <= bcd_i;
    end else if (shift) begin
      dig_q <= {dig_q[BCD_W-DB-1:0], {DB{1'b0}}};
    end
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  assign empty_o     = !out_valid_q;
  assign character_o = out_char_q;
  assign last_char_o = out_last_q;

endmodule

// ----- hw/rtl/i2d_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_checker: port-level assertions for the decimal converter
// Watches the result side for held payload, legal characters and text form.
// ----------------------------------------------------------------------------
module i2d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pop,
  input logic       empty,
  input logic [7:0] character_o,
  input logic       last_char_o
);

  logic take;
  logic at_start_q;  // next character opens a number or follows its sign
  logic in_text_q;   // a number's text has started and not yet ended

  assign take = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      in_text_q  <= 1'b0;
    end else if (take) begin
      at_start_q <= last_char_o || (character_o == i2d_pkg::CHAR_MINUS);
      in_text_q  <= !last_char_o;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(character_o) && $stable(last_char_o))
    else $error("result changed while stalled");

  a_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (character_o == i2d_pkg::CHAR_MINUS) ||
               ((character_o >= i2d_pkg::CHAR_ZERO) &&
                (character_o <= i2d_pkg::CHAR_NINE)))
    else $error("illegal character");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (character_o == i2d_pkg::CHAR_MINUS) |-> !last_char_o)
    else $error("sign marked as final character");

  a_sign_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && in_text_q |-> character_o != i2d_pkg::CHAR_MINUS)
    else $error("sign inside a number");

  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && at_start_q && (character_o == i2d_pkg::CHAR_ZERO) |-> last_char_o)
    else $error("leading zero");

endmodule

bind int32_to_decimal_ascii i2d_checker u_i2d_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pop        (pop),
  .empty      (empty),
  .character_o(character_o),
  .last_char_o(last_char_o)
);
